// ===== src/tsfr_pkg.sv =====
// ----------------------------------------------------------------------------
// tsfr_pkg
// Shared types and constants of the two-slot fragment reassembly unit.
// ----------------------------------------------------------------------------
package tsfr_pkg;

   localparam int KIND_W      = 2;
   localparam int SSI_W       = 24;
   localparam int NOW_W       = 32;
   localparam int META_W      = 13;
   localparam int INFO_A_W    = 43;
   localparam int INFO_B_W    = 42;
   localparam int TIMEOUT_W   = 16;
   localparam int STATUS_W    = 3;
   localparam int IDX_W       = 2;
   localparam int CHUNK_W     = 49;
   localparam int OUT_CNT_W   = 32;
   localparam int REQ_DATA_W  = 160;
   localparam int RSP_DATA_W  = 160;

   // Info bit numbers at which the stored part and the end burst begin.
   localparam int FIRST_INFO_BIT = 30;
   localparam int END_INFO_BIT   = 7;
   localparam int FIRST_LOW      = FIRST_INFO_BIT - END_INFO_BIT;
   localparam int FIRST_W        = INFO_A_W - FIRST_LOW + INFO_B_W;
   localparam int BODY_W         = FIRST_W + INFO_A_W + INFO_B_W;

   localparam logic [KIND_W-1:0] KIND_TICK  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_FIRST = 2'd1;
   localparam logic [KIND_W-1:0] KIND_END   = 2'd2;

   typedef enum logic [1:0] {
      OP_TICK,
      OP_FIRST,
      OP_END,
      OP_NOP
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_TICK_DONE = 3'd0,
      STATUS_STORED    = 3'd1,
      STATUS_DROPPED   = 3'd2,
      STATUS_BODY      = 3'd3,
      STATUS_ORPHAN    = 3'd4
   } status_type;

   typedef struct packed {
      op_type                op;
      logic [SSI_W-1:0]      ssi;
      logic [NOW_W-1:0]      now_ms;
      logic [META_W-1:0]     meta;
      logic [INFO_A_W-1:0]   info_a;
      logic [INFO_B_W-1:0]   info_b;
   } entry_type;

endpackage

// ===== src/tsfr_front.sv =====
// ----------------------------------------------------------------------------
// tsfr_front
// Input side: unpacks an incoming item and decodes its kind into an operation.
// ----------------------------------------------------------------------------
module tsfr_front (
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [tsfr_pkg::REQ_DATA_W-1:0]    req_tdata,
   input  logic [tsfr_pkg::KIND_W-1:0]        req_tuser,
   input  logic                               q_full,
   output logic                               push_valid,
   output tsfr_pkg::entry_type                push_entry
);
   import tsfr_pkg::*;

   op_type op;

   always_comb begin
      unique case (req_tuser)
         KIND_TICK:  op = OP_TICK;
         KIND_FIRST: op = OP_FIRST;
         KIND_END:   op = OP_END;
         default:    op = OP_NOP;
      endcase
   end

   assign req_tready = !q_full;
   assign push_valid = req_tvalid && !q_full;

   always_comb begin
      push_entry.op     = op;
      push_entry.ssi    = req_tdata[23:0];
      push_entry.now_ms = req_tdata[55:24];
      push_entry.meta   = req_tdata[68:56];
      push_entry.info_a = req_tdata[111:69];
      push_entry.info_b = req_tdata[153:112];
   end

endmodule

// ===== src/tsfr_queue.sv =====
// ----------------------------------------------------------------------------
// tsfr_queue
// Short FIFO of decoded items between the input side and the slot engine.
// ----------------------------------------------------------------------------
module tsfr_queue #(
   parameter int DEPTH = 2
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push_valid,
   input  tsfr_pkg::entry_type   push_entry,
   output logic                  q_full,
   input  logic                  pop,
   output logic                  q_valid,
   output tsfr_pkg::entry_type   q_entry
);
   import tsfr_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

   entry_type        mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_pop;

   assign q_full  = (count_ff == CNT_W'(DEPTH));
   assign q_valid = (count_ff != '0);
   assign q_entry = mem_ff[rd_ptr_ff];
   assign do_pop  = pop && q_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_valid) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push_valid && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !push_valid) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ===== src/tsfr_back.sv =====
// ----------------------------------------------------------------------------
// tsfr_back
// Slot engine: applies one item to the two slots and the counters, then
// delivers its results one per cycle while rsp_tready is high, from the output registers.
// ----------------------------------------------------------------------------
module tsfr_back #(
   parameter int DEFAULT_TIMEOUT_MS = 1000,
   parameter int COUNT_BITS         = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [tsfr_pkg::TIMEOUT_W-1:0]      csr_wr_data,
   input  logic                                q_valid,
   input  tsfr_pkg::entry_type                 q_entry,
   output logic                                pop,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic                                rsp_tlast,
   output tsfr_pkg::status_type                rsp_status,
   output logic                                rsp_slot,
   output logic [tsfr_pkg::IDX_W-1:0]          rsp_chunk_index,
   output logic [tsfr_pkg::CHUNK_W-1:0]        rsp_body_chunk,
   output logic [tsfr_pkg::META_W-1:0]         rsp_meta,
   output logic [tsfr_pkg::SSI_W-1:0]          rsp_ssi,
   output logic [tsfr_pkg::OUT_CNT_W-1:0]      rsp_drop_count,
   output logic [tsfr_pkg::OUT_CNT_W-1:0]      rsp_reassembled_count
);
   import tsfr_pkg::*;

   typedef enum logic {
      ST_IDLE,
      ST_EMIT
   } state_type;

   localparam logic [IDX_W-1:0] LAST_CHUNK = 2'd2;

   state_type             state_ff, state_in;
   logic [TIMEOUT_W-1:0]  timeout_ff, timeout_in;
   logic [1:0]            slot_valid_ff, slot_valid_in;
   logic [SSI_W-1:0]      slot_id_ff    [2];
   logic [SSI_W-1:0]      slot_id_in    [2];
   logic [FIRST_W-1:0]    slot_first_ff [2];
   logic [FIRST_W-1:0]    slot_first_in [2];
   logic [META_W-1:0]     slot_meta_ff  [2];
   logic [META_W-1:0]     slot_meta_in  [2];
   logic [NOW_W-1:0]      slot_dl_ff    [2];
   logic [NOW_W-1:0]      slot_dl_in    [2];
   logic [COUNT_BITS-1:0] dropped_ff, dropped_in;
   logic [COUNT_BITS-1:0] completed_ff, completed_in;

   status_type            job_status_ff, job_status_in;
   logic                  job_slot_ff, job_slot_in;
   logic                  job_multi_ff, job_multi_in;
   logic [META_W-1:0]     job_meta_ff, job_meta_in;
   logic [SSI_W-1:0]      job_ssi_ff, job_ssi_in;
   logic [BODY_W-1:0]     job_body_ff, job_body_in;
   logic [IDX_W-1:0]      idx_ff, idx_in;

   logic                  last_now;
   logic                  hit0, hit1, expire0, expire1;
   logic [NOW_W-1:0]      diff0, diff1;
   logic [TIMEOUT_W-1:0]  timeout_eff;
   logic [FIRST_W-1:0]    first_bits;
   logic                  pick, pick_ok;

   assign last_now   = !job_multi_ff || (idx_ff == LAST_CHUNK);
   assign pop        = q_valid && ((state_ff == ST_IDLE) || (rsp_tready && last_now));

   assign hit0       = slot_valid_ff[0] && (slot_id_ff[0] == q_entry.ssi);
   assign hit1       = slot_valid_ff[1] && (slot_id_ff[1] == q_entry.ssi);
   assign diff0      = q_entry.now_ms - slot_dl_ff[0];
   assign diff1      = q_entry.now_ms - slot_dl_ff[1];
   assign expire0    = slot_valid_ff[0] && !diff0[NOW_W-1];
   assign expire1    = slot_valid_ff[1] && !diff1[NOW_W-1];
   assign timeout_eff = (timeout_ff == '0) ? TIMEOUT_W'(DEFAULT_TIMEOUT_MS) : timeout_ff;
   assign first_bits = {q_entry.info_b, q_entry.info_a[INFO_A_W-1:FIRST_LOW]};

   // Slot choice for a first fragment: a slot with the same identity, else
   // the lowest free slot.
   always_comb begin
      pick    = 1'b0;
      pick_ok = 1'b1;
      if (hit0) begin
         pick = 1'b0;
      end else if (hit1) begin
         pick = 1'b1;
      end else if (!slot_valid_ff[0]) begin
         pick = 1'b0;
      end else if (!slot_valid_ff[1]) begin
         pick = 1'b1;
      end else begin
         pick_ok = 1'b0;
      end
   end

   always_comb begin
      state_in      = state_ff;
      timeout_in    = csr_wr_en ? csr_wr_data : timeout_ff;
      slot_valid_in = slot_valid_ff;
      slot_id_in    = slot_id_ff;
      slot_first_in = slot_first_ff;
      slot_meta_in  = slot_meta_ff;
      slot_dl_in    = slot_dl_ff;
      dropped_in    = dropped_ff;
      completed_in  = completed_ff;
      job_status_in = job_status_ff;
      job_slot_in   = job_slot_ff;
      job_multi_in  = job_multi_ff;
      job_meta_in   = job_meta_ff;
      job_ssi_in    = job_ssi_ff;
      job_body_in   = job_body_ff;
      idx_in        = idx_ff;

      if (state_ff == ST_EMIT && rsp_tready) begin
         if (last_now) begin
            state_in = ST_IDLE;
         end else begin
            idx_in = idx_ff + 1'b1;
         end
      end

      if (pop) begin
         state_in      = ST_EMIT;
         idx_in        = '0;
         job_status_in = STATUS_TICK_DONE;
         job_slot_in   = 1'b0;
         job_multi_in  = 1'b0;
         job_meta_in   = '0;
         job_ssi_in    = '0;
         job_body_in   = '0;
         unique case (q_entry.op)
            OP_TICK: begin
               slot_valid_in = slot_valid_ff & ~{expire1, expire0};
               dropped_in    = dropped_ff + COUNT_BITS'(expire0) + COUNT_BITS'(expire1);
            end
            OP_FIRST: begin
               if (pick_ok) begin
                  slot_valid_in[pick] = 1'b1;
                  slot_id_in[pick]    = q_entry.ssi;
                  slot_first_in[pick] = first_bits;
                  slot_meta_in[pick]  = q_entry.meta;
                  slot_dl_in[pick]    = q_entry.now_ms + NOW_W'(timeout_eff);
                  job_status_in       = STATUS_STORED;
                  job_slot_in         = pick;
                  job_meta_in         = q_entry.meta;
                  job_ssi_in          = q_entry.ssi;
               end else begin
                  dropped_in    = dropped_ff + 1'b1;
                  job_status_in = STATUS_DROPPED;
               end
            end
            OP_END: begin
               if (hit0 || hit1) begin
                  slot_valid_in[!hit0] = 1'b0;
                  completed_in  = completed_ff + 1'b1;
                  job_status_in = STATUS_BODY;
                  job_slot_in   = !hit0;
                  job_multi_in  = 1'b1;
                  job_meta_in   = slot_meta_ff[!hit0];
                  job_ssi_in    = slot_id_ff[!hit0];
                  job_body_in   = {q_entry.info_b, q_entry.info_a, slot_first_ff[!hit0]};
               end else begin
                  job_status_in = STATUS_ORPHAN;
               end
            end
            default: begin
               job_status_in = STATUS_TICK_DONE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         timeout_ff    <= '0;
         slot_valid_ff <= '0;
         dropped_ff    <= '0;
         completed_ff  <= '0;
         job_multi_ff  <= 1'b0;
         idx_ff        <= '0;
      end else begin
         state_ff      <= state_in;
         timeout_ff    <= timeout_in;
         slot_valid_ff <= slot_valid_in;
         dropped_ff    <= dropped_in;
         completed_ff  <= completed_in;
         job_multi_ff  <= job_multi_in;
         idx_ff        <= idx_in;
      end
      slot_id_ff    <= slot_id_in;
      slot_first_ff <= slot_first_in;
      slot_meta_ff  <= slot_meta_in;
      slot_dl_ff    <= slot_dl_in;
      job_status_ff <= job_status_in;
      job_slot_ff   <= job_slot_in;
      job_meta_ff   <= job_meta_in;
      job_ssi_ff    <= job_ssi_in;
      job_body_ff   <= job_body_in;
   end

   always_comb begin
      case (idx_ff)
         2'd0:    rsp_body_chunk = job_body_ff[CHUNK_W-1:0];
         2'd1:    rsp_body_chunk = job_body_ff[2*CHUNK_W-1:CHUNK_W];
         default: rsp_body_chunk = job_body_ff[3*CHUNK_W-1:2*CHUNK_W];
      endcase
   end

   assign rsp_tvalid            = (state_ff == ST_EMIT);
   assign rsp_tlast             = last_now;
   assign rsp_status            = job_status_ff;
   assign rsp_slot              = job_slot_ff;
   assign rsp_chunk_index       = idx_ff;
   assign rsp_meta              = job_meta_ff;
   assign rsp_ssi               = job_ssi_ff;
   assign rsp_drop_count        = OUT_CNT_W'(dropped_ff);
   assign rsp_reassembled_count = OUT_CNT_W'(completed_ff);

endmodule

// ===== src/two_slot_fragment_reassembly_unit.sv =====
// ----------------------------------------------------------------------------
// two_slot_fragment_reassembly_unit
// Reassembles two-fragment uplink messages in two identity-keyed slots.
// ----------------------------------------------------------------------------
// Order: an accepted item is written into the queue, then the slot engine
// pops it and registers its first result in the output registers.
// Throughput: the slot engine gives one result per cycle while rsp_tready
// is high; an item gives one result, and an end fragment that matches a
// slot gives three body chunks.
// Reset is synchronous and active high; it empties the queue, frees both
// slots, clears both counters and sets the timeout register to zero.
module two_slot_fragment_reassembly_unit #(
   parameter int DEFAULT_TIMEOUT_MS = 1000,
   parameter int COUNT_BITS         = 32,
   parameter int QUEUE_DEPTH        = 2
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // Configuration: timeout_ms, to be written while the unit is idle (the unit does not check it).
   input  logic                                 csr_wr_en,
   input  logic [tsfr_pkg::TIMEOUT_W-1:0]       csr_wr_data,
   // Input items.
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // req_tdata from bit 0: ssi[23:0], now_ms[55:24], meta[68:56],
   // info_a[111:69], info_b[153:112], zero fill [159:154].
   input  logic [tsfr_pkg::REQ_DATA_W-1:0]      req_tdata,
   // req_tuser: kind[1:0].
   input  logic [tsfr_pkg::KIND_W-1:0]          req_tuser,
   // Result items.
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // rsp_tdata from bit 0: slot[0], chunk_index[2:1], body_chunk[51:3],
   // meta_out[64:52], ssi_out[88:65], drop_count[120:89],
   // reassembled_count[152:121], zero fill [159:153].
   output logic [tsfr_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   // rsp_tuser: status[2:0].
   output logic [tsfr_pkg::STATUS_W-1:0]        rsp_tuser,
   output logic                                 rsp_tlast
);
   import tsfr_pkg::*;

   // The input side only decodes and queues; it never looks at slot state,
   // so it keeps taking items while the slot engine drains a body, until the queue is full.
   logic                  push_valid;
   entry_type             push_entry;
   logic                  q_full;
   logic                  q_valid;
   entry_type             q_entry;
   logic                  pop;

   status_type            rsp_status;
   logic                  rsp_slot;
   logic [IDX_W-1:0]      rsp_chunk_index;
   logic [CHUNK_W-1:0]    rsp_body_chunk;
   logic [META_W-1:0]     rsp_meta;
   logic [SSI_W-1:0]      rsp_ssi;
   logic [OUT_CNT_W-1:0]  rsp_drop_count;
   logic [OUT_CNT_W-1:0]  rsp_reassembled_count;

   tsfr_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_full     (q_full),
      .push_valid (push_valid),
      .push_entry (push_entry)
   );

   tsfr_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .q_full     (q_full),
      .pop        (pop),
      .q_valid    (q_valid),
      .q_entry    (q_entry)
   );

   // The slot engine pulls the next item in the same cycle that the last
   // result of the current one is taken, so results stream without gaps while the queue holds items.
   tsfr_back #(
      .DEFAULT_TIMEOUT_MS (DEFAULT_TIMEOUT_MS),
      .COUNT_BITS         (COUNT_BITS)
   ) u_back (
      .clock                 (clock),
      .reset                 (reset),
      .csr_wr_en             (csr_wr_en),
      .csr_wr_data           (csr_wr_data),
      .q_valid               (q_valid),
      .q_entry               (q_entry),
      .pop                   (pop),
      .rsp_tvalid            (rsp_tvalid),
      .rsp_tready            (rsp_tready),
      .rsp_tlast             (rsp_tlast),
      .rsp_status            (rsp_status),
      .rsp_slot              (rsp_slot),
      .rsp_chunk_index       (rsp_chunk_index),
      .rsp_body_chunk        (rsp_body_chunk),
      .rsp_meta              (rsp_meta),
      .rsp_ssi               (rsp_ssi),
      .rsp_drop_count        (rsp_drop_count),
      .rsp_reassembled_count (rsp_reassembled_count)
   );

   // Pack the result fields; the counters always show their values after
   // the item that caused this result.
   assign rsp_tdata = {7'b0, rsp_reassembled_count, rsp_drop_count, rsp_ssi,
                       rsp_meta, rsp_body_chunk, rsp_chunk_index, rsp_slot};
   assign rsp_tuser = rsp_status;

endmodule

// ===== src/tsfr_checker.sv =====
// ----------------------------------------------------------------------------
// tsfr_checker
// Port-level checks on the result stream of the reassembly unit.
// ----------------------------------------------------------------------------
module tsfr_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [tsfr_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input logic [tsfr_pkg::STATUS_W-1:0]     rsp_tuser,
   input logic                              rsp_tlast
);
   import tsfr_pkg::*;

   // No result is offered right after reset.
   a_quiet_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result offered right after reset");

   // A stalled result keeps its payload.
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled result changed");

   // Every result other than a body chunk is the only one of its item.
   a_single_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser != STATUS_BODY) |-> rsp_tlast)
      else $error("single result without last");

   // A body chunk is last exactly when it is the third chunk.
   a_body_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == STATUS_BODY) |-> (rsp_tlast == (rsp_tdata[2:1] == 2'd2)))
      else $error("body chunk last flag wrong");

   // A taken body chunk that is not last is followed by the next chunk.
   a_body_follows: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && (rsp_tuser == STATUS_BODY) && !rsp_tlast
      |=> rsp_tvalid && (rsp_tuser == STATUS_BODY)
         && (rsp_tdata[2:1] == $past(rsp_tdata[2:1]) + 2'd1))
      else $error("body chunk sequence broken");

endmodule

bind two_slot_fragment_reassembly_unit tsfr_checker u_tsfr_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
